>>> hdl/sprg_pkg.sv
// shared constants, types and arithmetic helpers for the grid snap unit
package sprg_pkg;

  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int SCALE_W    = 24;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SCALE_FRAC = 16;
  localparam int TRIG_FRAC  = 14;
  localparam int MID_W      = 47;
  localparam int PROD_W     = MID_W + TRIG_W;

  // divide by scale: numerator 2*|p|*2^16 + scale, divisor 2*scale
  localparam int DIV1_NUM_W = COORD_W + SCALE_FRAC + 1;
  localparam int DIV1_DEN_W = SCALE_W + 1;
  // divide by step: numerator 2*|u - origin| + step, divisor 2*step
  localparam int DIV2_MAG_W = MID_W;
  localparam int DIV2_NUM_W = DIV2_MAG_W + 2;
  localparam int DIV2_DEN_W = STEP_W + 1;
  localparam int DIV2_TAG_W = DIV2_MAG_W + 1;

  localparam logic signed [63:0] MID_HI    = (64'sd1 <<< (MID_W - 1)) - 64'sd1;
  localparam logic signed [63:0] MID_LO    = -(64'sd1 <<< (MID_W - 1));
  localparam logic [63:0]        TRIG_HALF = 64'd1 << (TRIG_FRAC - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_STEP_X   = 3'd2,
    CFG_STEP_Y   = 3'd3,
    CFG_SCALE_X  = 3'd4,
    CFG_SCALE_Y  = 3'd5,
    CFG_COS      = 3'd6,
    CFG_SIN      = 3'd7
  } cfg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MID_W-1:0]   mid_t;

  function automatic mid_t clamp_mid(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MID_HI) begin
      r = MID_HI;
    end else if (v < MID_LO) begin
      r = MID_LO;
    end else begin
      r = v;
    end
    return mid_t'(r);
  endfunction

  // divide by 2^14, nearest, halves away from zero
  function automatic logic signed [63:0] rnd_trig(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + TRIG_HALF) >> TRIG_FRAC;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  // scale result rounding and saturation to the coordinate range
  function automatic coord_t out_sat(input logic neg, input logic [71:0] prod);
    logic [71:0] r;
    logic [71:0] lim;
    r   = (prod + (72'd1 << (SCALE_FRAC - 1))) >> SCALE_FRAC;
    lim = 72'd1 << (COORD_W - 1);
    if (neg) begin
      if (r > lim) r = lim;
      return coord_t'(72'd0 - r);
    end else begin
      if (r > lim - 72'd1) r = lim - 72'd1;
      return coord_t'(r);
    end
  endfunction

endpackage

>>> hdl/sprg_if.sv
// point and snapped point channels
interface sprg_in_if;
  import sprg_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface sprg_out_if;
  import sprg_pkg::*;
  logic   valid;
  logic   ready;
  coord_t snapped_x;
  coord_t snapped_y;
  modport source (output valid, output snapped_x, output snapped_y, input ready);
  modport sink (input valid, input snapped_x, input snapped_y, output ready);
endinterface

>>> hdl/sprg_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module sprg_div_pipe #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 25,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [TAG_W-1:0] tag_o
);

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [NUM_W-1:0] q_in;
    logic [NUM_W-1:0] n_in;
    logic [TAG_W-1:0] t_in;
    logic [DEN_W:0]   trial;
    logic             fit;
    logic [DEN_W-1:0] rem_q;
    logic [NUM_W-1:0] quot_q;
    logic [NUM_W-1:0] num_q;
    logic [TAG_W-1:0] tag_q;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = num_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign r_in = g_stage[i-1].rem_q;
      assign q_in = g_stage[i-1].quot_q;
      assign n_in = g_stage[i-1].num_q;
      assign t_in = g_stage[i-1].tag_q;
    end

    assign trial = {r_in, n_in[NUM_W-1]};
    assign fit   = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= fit ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
        quot_q <= {q_in[NUM_W-2:0], fit};
        num_q  <= {n_in[NUM_W-2:0], 1'b0};
        tag_q  <= t_in;
      end
    end
  end

  assign quot_o = g_stage[NUM_W-1].quot_q;
  assign rem_o  = g_stage[NUM_W-1].rem_q;
  assign tag_o  = g_stage[NUM_W-1].tag_q;

endmodule

>>> hdl/snap_point_to_rotated_grid_unit.sv
// snap a point to a rotated, scaled grid, fully pipelined
//
//   channel   dir  handshake      payload
//   point_i   in   valid/ready    point_x, point_y
//   snap_o    out  valid/ready    snapped_x, snapped_y
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one transaction enters per cycle while the output is not stalled
// most of the pipeline depth is in the 49-stage dividers (by scale and by step)
// reset clears the valid chain and loads the register defaults
// a stall at the output freezes every stage; an empty last stage never holds the pipe
module snap_point_to_rotated_grid_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sprg_in_if.sink                            point_i,
  sprg_out_if.source                         snap_o,
  input  logic                               cfg_we_i,
  input  logic [sprg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sprg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sprg_pkg::*;

  localparam int LAT = 1 + DIV1_NUM_W + 4 + DIV2_NUM_W + 5;

  coord_t                    origin_x_q, origin_y_q;
  logic [STEP_W-1:0]         step_x_q, step_y_q;
  logic [SCALE_W-1:0]        scale_x_q, scale_y_q;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      step_x_q   <= STEP_W'(65536);
      step_y_q   <= STEP_W'(65536);
      scale_x_q  <= SCALE_W'(65536);
      scale_y_q  <= SCALE_W'(65536);
      cos_q      <= TRIG_W'(16384);
      sin_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: origin_x_q <= coord_t'(cfg_data_i);
        CFG_ORIGIN_Y: origin_y_q <= coord_t'(cfg_data_i);
        CFG_STEP_X:   step_x_q   <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_Y:   step_y_q   <= cfg_data_i[STEP_W-1:0];
        CFG_SCALE_X:  scale_x_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_Y:  scale_y_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_COS:      cos_q      <= TRIG_W'(cfg_data_i);
        CFG_SIN:      sin_q      <= TRIG_W'(cfg_data_i);
      endcase
    end
  end

  // zero scale or step acts as one lsb
  logic [SCALE_W-1:0] scx, scy;
  logic [STEP_W-1:0]  stx, sty;
  assign scx = (scale_x_q == '0) ? SCALE_W'(1) : scale_x_q;
  assign scy = (scale_y_q == '0) ? SCALE_W'(1) : scale_y_q;
  assign stx = (step_x_q == '0) ? STEP_W'(1) : step_x_q;
  assign sty = (step_y_q == '0) ? STEP_W'(1) : step_y_q;

  // flow control
  logic [LAT-1:0] vld_q;
  logic           en;
  assign en            = !vld_q[LAT-1] || snap_o.ready;
  assign point_i.ready = en;
  assign snap_o.valid  = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], point_i.valid};
    end
  end

  // input register
  coord_t px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= point_i.point_x;
      py_q <= point_i.point_y;
    end
  end

  // divide by scale
  logic [COORD_W:0]      mag1x, mag1y;
  logic [DIV1_NUM_W-1:0] n1x, n1y, q1x, q1y;
  logic                  neg1x, neg1y;
  assign mag1x = px_q[COORD_W-1] ? (33'd0 - {px_q[COORD_W-1], px_q}) : {1'b0, px_q};
  assign mag1y = py_q[COORD_W-1] ? (33'd0 - {py_q[COORD_W-1], py_q}) : {1'b0, py_q};
  assign n1x   = DIV1_NUM_W'({mag1x, 17'd0}) + DIV1_NUM_W'(scx);
  assign n1y   = DIV1_NUM_W'({mag1y, 17'd0}) + DIV1_NUM_W'(scy);

  sprg_div_pipe #(.NUM_W(DIV1_NUM_W), .DEN_W(DIV1_DEN_W), .TAG_W(1)) u_div1x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (n1x),
    .den_i  ({scx, 1'b0}),
    .tag_i  (px_q[COORD_W-1]),
    .quot_o (q1x),
    .rem_o  (),
    .tag_o  (neg1x)
  );

  sprg_div_pipe #(.NUM_W(DIV1_NUM_W), .DEN_W(DIV1_DEN_W), .TAG_W(1)) u_div1y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (n1y),
    .den_i  ({scy, 1'b0}),
    .tag_i  (py_q[COORD_W-1]),
    .quot_o (q1y),
    .rem_o  (),
    .tag_o  (neg1y)
  );

  mid_t qx_q, qy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= clamp_mid(neg1x ? -$signed(64'(q1x)) : $signed(64'(q1x)));
      qy_q <= clamp_mid(neg1y ? -$signed(64'(q1y)) : $signed(64'(q1y)));
    end
  end

  // unrotate
  logic signed [PROD_W-1:0] cqx_q, sqy_q, cqy_q, sqx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cqx_q <= cos_q * qx_q;
      sqy_q <= sin_q * qy_q;
      cqy_q <= cos_q * qy_q;
      sqx_q <= sin_q * qx_q;
    end
  end

  mid_t ux_q, uy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= clamp_mid(rnd_trig(64'(cqx_q) + 64'(sqy_q)));
      uy_q <= clamp_mid(rnd_trig(64'(cqy_q) - 64'(sqx_q)));
    end
  end

  // divide by step
  logic signed [DIV2_MAG_W:0] d2x, d2y;
  logic [DIV2_MAG_W-1:0]      mag2x, mag2y;
  assign d2x   = (DIV2_MAG_W+1)'(ux_q) - (DIV2_MAG_W+1)'(origin_x_q);
  assign d2y   = (DIV2_MAG_W+1)'(uy_q) - (DIV2_MAG_W+1)'(origin_y_q);
  assign mag2x = DIV2_MAG_W'(d2x[DIV2_MAG_W] ? -d2x : d2x);
  assign mag2y = DIV2_MAG_W'(d2y[DIV2_MAG_W] ? -d2y : d2y);

  logic [DIV2_NUM_W-1:0] n2x_q, n2y_q;
  logic [DIV2_TAG_W-1:0] t2x_q, t2y_q, t2x, t2y;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n2x_q <= DIV2_NUM_W'({mag2x, 1'b0}) + DIV2_NUM_W'(stx);
      n2y_q <= DIV2_NUM_W'({mag2y, 1'b0}) + DIV2_NUM_W'(sty);
      t2x_q <= {d2x[DIV2_MAG_W], mag2x};
      t2y_q <= {d2y[DIV2_MAG_W], mag2y};
    end
  end

  logic [DIV2_DEN_W-1:0] r2x, r2y;

  sprg_div_pipe #(.NUM_W(DIV2_NUM_W), .DEN_W(DIV2_DEN_W), .TAG_W(DIV2_TAG_W)) u_div2x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (n2x_q),
    .den_i  ({stx, 1'b0}),
    .tag_i  (t2x_q),
    .quot_o (),
    .rem_o  (r2x),
    .tag_o  (t2x)
  );

  sprg_div_pipe #(.NUM_W(DIV2_NUM_W), .DEN_W(DIV2_DEN_W), .TAG_W(DIV2_TAG_W)) u_div2y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (n2y_q),
    .den_i  ({sty, 1'b0}),
    .tag_i  (t2y_q),
    .quot_o (),
    .rem_o  (r2y),
    .tag_o  (t2y)
  );

  // quotient times step = mag + (step - rem) / 2
  logic signed [DIV2_DEN_W:0] hx, hy;
  logic signed [63:0]         mx, my, gvx, gvy;
  assign hx  = ($signed({2'b0, stx}) - $signed({1'b0, r2x})) >>> 1;
  assign hy  = ($signed({2'b0, sty}) - $signed({1'b0, r2y})) >>> 1;
  assign mx  = $signed(64'(t2x[DIV2_MAG_W-1:0])) + 64'(hx);
  assign my  = $signed(64'(t2y[DIV2_MAG_W-1:0])) + 64'(hy);
  assign gvx = (t2x[DIV2_MAG_W] ? -mx : mx) + 64'(origin_x_q);
  assign gvy = (t2y[DIV2_MAG_W] ? -my : my) + 64'(origin_y_q);

  mid_t gx_q, gy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q <= clamp_mid(gvx);
      gy_q <= clamp_mid(gvy);
    end
  end

  // rotate back
  logic signed [PROD_W-1:0] cgx_q, sgy_q, sgx_q, cgy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cgx_q <= cos_q * gx_q;
      sgy_q <= sin_q * gy_q;
      sgx_q <= sin_q * gx_q;
      cgy_q <= cos_q * gy_q;
    end
  end

  mid_t vx_q, vy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q <= clamp_mid(rnd_trig(64'(cgx_q) - 64'(sgy_q)));
      vy_q <= clamp_mid(rnd_trig(64'(sgx_q) + 64'(cgy_q)));
    end
  end

  // scale, split into two partial products
  logic [MID_W-1:0] magvx, magvy;
  assign magvx = MID_W'(vx_q[MID_W-1] ? -vx_q : vx_q);
  assign magvy = MID_W'(vy_q[MID_W-1] ? -vy_q : vy_q);

  logic [2*SCALE_W-1:0]             plx_q, ply_q;
  logic [MID_W-SCALE_W+SCALE_W-1:0] phx_q, phy_q;
  logic                             nvx_q, nvy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      plx_q <= magvx[SCALE_W-1:0] * scx;
      ply_q <= magvy[SCALE_W-1:0] * scy;
      phx_q <= magvx[MID_W-1:SCALE_W] * scx;
      phy_q <= magvy[MID_W-1:SCALE_W] * scy;
      nvx_q <= vx_q[MID_W-1];
      nvy_q <= vy_q[MID_W-1];
    end
  end

  coord_t sx_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= out_sat(nvx_q, 72'({phx_q, 24'd0}) + 72'(plx_q));
      sy_q <= out_sat(nvy_q, 72'({phy_q, 24'd0}) + 72'(ply_q));
    end
  end

  assign snap_o.snapped_x = sx_q;
  assign snap_o.snapped_y = sy_q;

endmodule
